>>> sv/prabc_pkg.sv
package prabc_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned StepW = 32;
  localparam int unsigned BoxW  = 31;
  localparam int unsigned FactW = 16;

  localparam logic [CodeW-1:0] CodeLine = 8'd1;
  localparam logic [CodeW-1:0] CodeArc  = 8'd4;

  localparam logic CfgCos = 1'b0;
  localparam logic CfgSin = 1'b1;

  typedef struct packed {
    logic [CodeW-1:0]        pen_code;
    logic signed [StepW-1:0] step_x;
    logic signed [StepW-1:0] step_y;
    logic                    last_step;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0]        out_code;
    logic signed [StepW-1:0] out_x;
    logic signed [StepW-1:0] out_y;
    logic                    out_last;
    logic [BoxW-1:0]         box_width;
    logic [BoxW-1:0]         box_height;
    logic                    overflowed;
  } out_word_t;

  typedef enum logic [2:0] {
    StLoad,
    StBox0,
    StRot,
    StBox1,
    StEmit,
    StOut
  } state_e;

endpackage

>>> sv/path_rotate_about_box_center.sv
// Collects a path of relative steps into on-chip point memories, one word per
// cycle, until a word marked last arrives; the input then stalls until the last
// result word of that path has been accepted. Processing sweeps the memory four
// times through one registered read port: the box of the original path (a read
// and then the box update per point), rotation about its center with the results
// written back (per point: read, offset from the center, four (COORD_BITS+2) x 16
// products together, then rounding and write-back), the rotated box, and emission
// (per point: read, output register, then the handshake, held while the receiver
// stalls).
module path_rotate_about_box_center import prabc_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [FactW-1:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned WB = CB + 2;
  localparam int unsigned PB = WB + FactW + 2;
  localparam logic signed [WB-1:0] CMax = WB'((64'sd1 <<< (CB - 1)) - 1);
  localparam logic signed [WB-1:0] CMin = -CMax - WB'(1);

  function automatic logic signed [WB-1:0] sat_c(input logic signed [WB+16:0] v);
    if (v > (WB+17)'(CMax)) return CMax;
    if (v < (WB+17)'(CMin)) return CMin;
    return WB'(v);
  endfunction

  // Memories: absolute points and pen codes.
  logic signed [CB-1:0] mem_x [MAX_POINTS];
  logic signed [CB-1:0] mem_y [MAX_POINTS];
  logic [CodeW-1:0]     mem_c [MAX_POINTS];

  logic signed [FactW-1:0] cos_q, sin_q;
  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, idx_q;
  logic drop_q;
  logic signed [CB-1:0] run_x_q, run_y_q;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic signed [CB-1:0] wx, wy;
  logic signed [CB-1:0] rdx_q, rdy_q;
  logic [CodeW-1:0]     rdc_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[wa] <= wx;
      mem_y[wa] <= wy;
    end
    if (in_valid_i && !in_stall_o && cnt_q < CW'(MAX_POINTS))
      mem_c[wa] <= in_word_i.pen_code;
    rdx_q <= mem_x[ra];
    rdy_q <= mem_y[ra];
    rdc_q <= mem_c[ra];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 16'sd16384;
      sin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCos: cos_q <= cfg_data_i;
        CfgSin: sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [FactW-1:0] cc, ss;
  always_comb begin
    cc = (cos_q > 16'sd16384) ? 16'sd16384 : (cos_q < -16'sd16384 ? -16'sd16384 : cos_q);
    ss = (sin_q > 16'sd16384) ? 16'sd16384 : (sin_q < -16'sd16384 ? -16'sd16384 : sin_q);
  end

  // Sweep bookkeeping: previous point, phase in rotation, box registers.
  logic [1:0] ph_q;
  logic rd_q;                  // read data valid this cycle
  logic [CW-1:0] rdi_q;        // index of read data
  logic signed [CB-1:0] px_q, py_q;
  logic bv_q;
  logic signed [CB-1:0] mnx_q, mxx_q, mny_q, mxy_q;
  logic ov_q;
  logic signed [CB-1:0] omnx_q, omny_q;
  logic signed [CB-1:0] cx_q, cy_q;
  logic signed [WB-1:0] dx_q, dy_q;
  logic signed [PB-1:0] m1_q, m2_q;
  logic signed [WB-1:0] sx_q, sy_q;
  logic [BoxW-1:0] w_q, h_q;
  logic out_v_q;
  out_word_t out_q;

  logic load_acc;
  assign in_stall_o = (state_q != StLoad);
  assign load_acc   = in_valid_i && !in_stall_o;

  // Input accumulation.
  logic signed [CB-1:0] nrx, nry;
  always_comb begin
    nrx = CB'(sat_c((WB+17)'(run_x_q) + (WB+17)'(in_word_i.step_x)));
    nry = CB'(sat_c((WB+17)'(run_y_q) + (WB+17)'(in_word_i.step_y)));
  end

  // Box growth of one point.
  logic draw;
  assign draw = (rdc_q == CodeLine) || (rdc_q == CodeArc);

  logic sweep_done;
  assign sweep_done = rd_q && (rdi_q == cnt_q - CW'(1));

  // Rotation products.
  logic signed [PB-1:0] rx_full, ry_full;
  logic signed [WB-1:0] rxs, rys;
  always_comb begin
    rx_full = (m1_q + PB'(8192)) >>> 14;
    ry_full = (m2_q + PB'(8192)) >>> 14;
    rxs = sat_c((WB+17)'(cx_q) + (WB+17)'(rx_full));
    rys = sat_c((WB+17)'(cy_q) + (WB+17)'(ry_full));
  end

  // Emission values.
  logic signed [WB-1:0] ex, ey, pex, pey, odx, ody;
  always_comb begin
    ex  = sat_c((WB+17)'(rdx_q) + (WB+17)'(sx_q));
    ey  = sat_c((WB+17)'(rdy_q) + (WB+17)'(sy_q));
    pex = sat_c((WB+17)'(px_q) + (WB+17)'(sx_q));
    pey = sat_c((WB+17)'(py_q) + (WB+17)'(sy_q));
    odx = (rdi_q == '0) ? ex : sat_c((WB+17)'(ex) - (WB+17)'(pex));
    ody = (rdi_q == '0) ? ey : sat_c((WB+17)'(ey) - (WB+17)'(pey));
  end

  function automatic logic signed [StepW-1:0] sat32(input logic signed [WB-1:0] v);
    if (64'(v) > 64'sd2147483647) return 32'sh7fffffff;
    if (64'(v) < -64'sd2147483648) return 32'sh80000000;
    return StepW'(v);
  endfunction

  function automatic logic [BoxW-1:0] sz(input logic signed [CB-1:0] lo,
                                         input logic signed [CB-1:0] hi);
    logic signed [CB:0] d;
    d = (CB+1)'(hi) - (CB+1)'(lo);
    if (64'(d) > 64'sd2147483647) return '1;
    return BoxW'(d);
  endfunction

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: if (load_acc && in_word_i.last_step) state_d = StBox0;
      StBox0: if (sweep_done) state_d = StRot;
      StRot:  if (ph_q == 2'd3 && idx_q == cnt_q - CW'(1)) state_d = StBox1;
      StBox1: if (sweep_done) state_d = StEmit;
      StEmit: if (rd_q) state_d = StOut;
      StOut:  if (!out_stall_i) state_d = out_q.out_last ? StLoad : StEmit;
      default: state_d = StLoad;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    wa = AW'(cnt_q);
    wx = nrx;
    wy = nry;
    ra = AW'(idx_q);
    unique case (state_q)
      StLoad: we = load_acc && (cnt_q < CW'(MAX_POINTS));
      StRot: begin
        wa = AW'(idx_q);
        wx = CB'(rxs);
        wy = CB'(rys);
        we = (ph_q == 2'd3);
      end
      default: ;
    endcase
  end

  logic issue;
  assign issue = ((state_q == StBox0) || (state_q == StBox1) || (state_q == StEmit))
                 && (idx_q < cnt_q) && !rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
      run_x_q <= '0;
      run_y_q <= '0;
      ph_q    <= '0;
      rd_q    <= 1'b0;
      out_v_q <= 1'b0;
      bv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= issue;
      if (issue) begin
        rdi_q <= idx_q;
        idx_q <= idx_q + CW'(1);
      end
      unique case (state_q)
        StLoad: begin
          if (load_acc) begin
            if (cnt_q < CW'(MAX_POINTS)) begin
              run_x_q <= nrx;
              run_y_q <= nry;
              cnt_q   <= cnt_q + CW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            idx_q <= '0;
            bv_q  <= 1'b0;
          end
        end
        StBox0, StBox1: begin
          if (rd_q) begin
            if (draw) begin
              if (!bv_q || rdi_q == '0) begin
                logic signed [CB-1:0] sx0, sy0;
                sx0 = (rdi_q == '0) ? '0 : px_q;
                sy0 = (rdi_q == '0) ? '0 : py_q;
                if (!bv_q) begin
                  mnx_q <= (sx0 < rdx_q) ? sx0 : rdx_q;
                  mxx_q <= (sx0 > rdx_q) ? sx0 : rdx_q;
                  mny_q <= (sy0 < rdy_q) ? sy0 : rdy_q;
                  mxy_q <= (sy0 > rdy_q) ? sy0 : rdy_q;
                end
              end
              if (bv_q) begin
                if (px_q  < mnx_q && !(rdx_q < px_q)) mnx_q <= px_q;
                else if (rdx_q < mnx_q && rdx_q <= px_q) mnx_q <= rdx_q;
                if (px_q  > mxx_q && !(rdx_q > px_q)) mxx_q <= px_q;
                else if (rdx_q > mxx_q && rdx_q >= px_q) mxx_q <= rdx_q;
                if (py_q  < mny_q && !(rdy_q < py_q)) mny_q <= py_q;
                else if (rdy_q < mny_q && rdy_q <= py_q) mny_q <= rdy_q;
                if (py_q  > mxy_q && !(rdy_q > py_q)) mxy_q <= py_q;
                else if (rdy_q > mxy_q && rdy_q >= py_q) mxy_q <= rdy_q;
              end
              bv_q <= 1'b1;
            end
            px_q <= rdx_q;
            py_q <= rdy_q;
          end
          if (sweep_done) begin
            idx_q <= '0;
            ph_q  <= '0;
          end
        end
        default: ;
      endcase
      // Original box and center, taken at rotation start (last update has landed).
      if (state_q == StRot && ph_q == 2'd0 && idx_q == '0) begin
        ov_q   <= bv_q;
        omnx_q <= mnx_q;
        omny_q <= mny_q;
        cx_q <= bv_q ? CB'(mnx_q + CB'(((CB+1)'(mxx_q) - (CB+1)'(mnx_q)) >>> 1)) : '0;
        cy_q <= bv_q ? CB'(mny_q + CB'(((CB+1)'(mxy_q) - (CB+1)'(mny_q)) >>> 1)) : '0;
      end
      if (state_q == StRot) begin
        unique case (ph_q)
          2'd0: ph_q <= 2'd1;
          2'd1: begin
            dx_q <= WB'(rdx_q) - WB'(cx_q);
            dy_q <= WB'(rdy_q) - WB'(cy_q);
            ph_q <= 2'd2;
          end
          2'd2: begin
            m1_q <= PB'(dx_q) * PB'(cc) - PB'(dy_q) * PB'(ss);
            m2_q <= PB'(dx_q) * PB'(ss) + PB'(dy_q) * PB'(cc);
            ph_q <= 2'd3;
          end
          default: begin
            ph_q  <= '0;
            if (idx_q == cnt_q - CW'(1)) begin
              idx_q <= '0;
              bv_q  <= 1'b0;
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        endcase
      end
      if (state_q == StEmit && rd_q) begin
        out_q.out_code   <= rdc_q;
        out_q.out_x      <= sat32(odx);
        out_q.out_y      <= sat32(ody);
        out_q.out_last   <= (rdi_q == cnt_q - CW'(1));
        out_q.box_width  <= w_q;
        out_q.box_height <= h_q;
        out_q.overflowed <= drop_q;
        out_v_q <= 1'b1;
        px_q <= rdx_q;
        py_q <= rdy_q;
      end
      if (state_q == StOut && !out_stall_i) begin
        out_v_q <= 1'b0;
        if (out_q.out_last) begin
          cnt_q   <= '0;
          drop_q  <= 1'b0;
          run_x_q <= '0;
          run_y_q <= '0;
        end
      end
    end
  end

  // Shift and box size of the rotated path, taken once the rotated box is final.
  logic box1_end_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box1_end_q <= 1'b0;
    end else begin
      box1_end_q <= (state_q == StBox1) && sweep_done;
    end
  end
  always_ff @(posedge clk_i) begin
    if (box1_end_q) begin
      if (ov_q && bv_q) begin
        sx_q <= WB'(omnx_q) - WB'(mnx_q);
        sy_q <= WB'(omny_q) - WB'(mny_q);
        w_q  <= sz(mnx_q, mxx_q);
        h_q  <= sz(mny_q, mxy_q);
      end else begin
        sx_q <= '0;
        sy_q <= '0;
        w_q  <= '0;
        h_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q && (state_q == StOut);
  assign out_word_o  = out_q;

endmodule
